@@ hw/rtl/nrpd_pkg.sv @@
// ----------------------------------------------------------------------------
// nrpd_pkg
// Shared types and constants for the nibble run-length palette decoder.
// ----------------------------------------------------------------------------
package nrpd_pkg;

  localparam int COLOUR_WIDTH_DEF = 32;
  localparam int PALETTE_DEPTH    = 16;
  localparam int PAL_AW           = $clog2(PALETTE_DEPTH);
  localparam int NIBBLE_W         = 4;
  localparam int CFG_W            = 16;
  localparam int CFG_IDX_W        = 3;
  localparam int SKIP_W           = 32;
  localparam int PIXEL_W          = 32;

  localparam logic [CFG_W-1:0] COLUMN_HEIGHT_RST = 16'd1;
  localparam logic [CFG_W-1:0] VISIBLE_LINES_RST = 16'd1;

  typedef enum logic [1:0] {
    FUNC_LOAD  = 2'd0,
    FUNC_START = 2'd1,
    FUNC_DATA  = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SKIP_COLUMNS  = 3'd0,
    REG_COLUMN_HEIGHT = 3'd1,
    REG_TOP_SKIP      = 3'd2,
    REG_GAP_SKIP      = 3'd3,
    REG_VISIBLE_LINES = 3'd4
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_ADD,
    S_RUN,
    S_FLUSH
  } seq_state_t;

  typedef struct packed {
    logic [CFG_W-1:0] skip_columns;
    logic [CFG_W-1:0] column_height;
    logic [CFG_W-1:0] top_skip;
    logic [CFG_W-1:0] gap_skip;
    logic [CFG_W-1:0] visible_lines;
  } cfg_t;

  typedef struct packed {
    logic vld;
    logic col_end;
    logic last;
  } push_t;

endpackage

@@ hw/rtl/nrpd_palette_ram.sv @@
// ----------------------------------------------------------------------------
// nrpd_palette_ram
// Palette store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module nrpd_palette_ram import nrpd_pkg::*; #(
  parameter int COLOUR_WIDTH = COLOUR_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    wr_en,
  input  logic [PAL_AW-1:0]       wr_addr,
  input  logic [COLOUR_WIDTH-1:0] wr_data,
  input  logic                    rd_en,
  input  logic [PAL_AW-1:0]       rd_addr,
  output logic [COLOUR_WIDTH-1:0] rd_data_r
);

  logic [COLOUR_WIDTH-1:0] mem [PALETTE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

@@ hw/rtl/nrpd_seq.sv @@
// ----------------------------------------------------------------------------
// nrpd_seq
// Sequencer: skip and line counters, run stepping, one-deep pixel hold-back.
// ----------------------------------------------------------------------------
module nrpd_seq import nrpd_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  func_t               func,
  input  logic [NIBBLE_W-1:0] run_len,
  input  cfg_t                cfg,
  input  logic                out_free,
  output logic                idle,
  output push_t               push
);

  seq_state_t          state_r, state_nxt;
  logic [NIBBLE_W-1:0] cnt_r, cnt_nxt;
  logic [SKIP_W-1:0]   skip_left_r, skip_left_nxt;
  logic [CFG_W-1:0]    lines_left_r, lines_left_nxt;
  logic                pend_vld_r, pend_vld_nxt;
  logic                pend_col_end_r, pend_col_end_nxt;
  logic                col_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      cnt_r          <= '0;
      skip_left_r    <= '0;
      lines_left_r   <= VISIBLE_LINES_RST;
      pend_vld_r     <= 1'b0;
      pend_col_end_r <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      cnt_r          <= cnt_nxt;
      skip_left_r    <= skip_left_nxt;
      lines_left_r   <= lines_left_nxt;
      pend_vld_r     <= pend_vld_nxt;
      pend_col_end_r <= pend_col_end_nxt;
    end
  end

  always_comb begin
    state_nxt        = state_r;
    cnt_nxt          = cnt_r;
    skip_left_nxt    = skip_left_r;
    lines_left_nxt   = lines_left_r;
    pend_vld_nxt     = pend_vld_r;
    pend_col_end_nxt = pend_col_end_r;
    push             = '0;
    col_end          = (lines_left_r <= CFG_W'(1));
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (func)
            FUNC_START: begin
              lines_left_nxt = cfg.visible_lines;
              state_nxt      = S_MUL;
            end
            FUNC_DATA: begin
              cnt_nxt      = run_len;
              pend_vld_nxt = 1'b0;
              state_nxt    = S_RUN;
            end
            default: ;
          endcase
        end
      end
      S_MUL: begin
        skip_left_nxt = {16'd0, cfg.skip_columns} * {16'd0, cfg.column_height};
        state_nxt     = S_ADD;
      end
      S_ADD: begin
        skip_left_nxt = skip_left_r + SKIP_W'(cfg.top_skip);
        state_nxt     = S_IDLE;
      end
      S_RUN: begin
        if (out_free) begin
          if (skip_left_r != '0) begin
            skip_left_nxt = skip_left_r - SKIP_W'(1);
          end else begin
            if (col_end) begin
              skip_left_nxt  = SKIP_W'(cfg.gap_skip);
              lines_left_nxt = cfg.visible_lines;
            end else begin
              lines_left_nxt = lines_left_r - CFG_W'(1);
            end
            // release the held pixel: a newer one follows it
            if (pend_vld_r) begin
              push.vld     = 1'b1;
              push.col_end = pend_col_end_r;
            end
            pend_vld_nxt     = 1'b1;
            pend_col_end_nxt = col_end;
          end
          if (cnt_r == '0) begin
            state_nxt = S_FLUSH;
          end else begin
            cnt_nxt = cnt_r - NIBBLE_W'(1);
          end
        end
      end
      S_FLUSH: begin
        if (!pend_vld_r) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          push.vld     = 1'b1;
          push.col_end = pend_col_end_r;
          push.last    = 1'b1;
          pend_vld_nxt = 1'b0;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign idle = (state_r == S_IDLE);

endmodule

@@ hw/rtl/nibble_rle_palette_decoder_unit.sv @@
// ----------------------------------------------------------------------------
// nibble_rle_palette_decoder_unit
// Column-ordered run-length decoder with a 16-entry palette.
// ----------------------------------------------------------------------------
// Takes one input item at a time. A palette load finishes in the cycle it is
// accepted; a start item steps through accept, multiply and add top skip.
// A data byte with run length n (1..16) occupies the block for the palette
// RAM read, one step per run pixel through the skip/line counters, and a
// flush of the held-back pixel that carries the last flag. Output stalls
// hold the run and flush steps. Configuration writes are accepted every cycle
// and take effect at the next start item or column end. Palette entries read
// before being loaded return unspecified values.
// ----------------------------------------------------------------------------
module nibble_rle_palette_decoder_unit import nrpd_pkg::*; #(
  parameter int COLOUR_WIDTH = COLOUR_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // input items
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_func,
  input  logic [PAL_AW-1:0]    in_palette_index,
  input  logic [PIXEL_W-1:0]   in_palette_value,
  input  logic [7:0]           in_data_byte,
  // result items
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [PIXEL_W-1:0]   out_pixel,
  output logic                 out_column_end,
  output logic                 out_last,
  // register writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  cfg_t                    cfg_r;
  logic                    in_fire;
  logic                    cfg_fire;
  func_t                   func;
  logic                    seq_idle;
  logic                    out_free;
  push_t                   push;
  logic [COLOUR_WIDTH-1:0] rd_data;

  logic                    out_valid_r;
  logic [COLOUR_WIDTH-1:0] out_pixel_r;
  logic                    out_column_end_r;
  logic                    out_last_r;

  assign func     = func_t'(in_func);
  assign in_ready = seq_idle;
  assign in_fire  = in_valid && in_ready;

  // Register file: always ready, out-of-range indexes drop silently.
  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.skip_columns  <= '0;
      cfg_r.column_height <= COLUMN_HEIGHT_RST;
      cfg_r.top_skip      <= '0;
      cfg_r.gap_skip      <= '0;
      cfg_r.visible_lines <= VISIBLE_LINES_RST;
    end else if (cfg_fire) begin
      unique case (cfg_index)
        REG_SKIP_COLUMNS:  cfg_r.skip_columns  <= cfg_data;
        REG_COLUMN_HEIGHT: cfg_r.column_height <= cfg_data;
        REG_TOP_SKIP:      cfg_r.top_skip      <= cfg_data;
        REG_GAP_SKIP:      cfg_r.gap_skip      <= cfg_data;
        REG_VISIBLE_LINES: cfg_r.visible_lines <= cfg_data;
        default: ;
      endcase
    end
  end

  // Palette: write on a load transfer, read the run's colour on a data transfer.
  // The read data holds for the whole run since no other read occurs meanwhile.
  nrpd_palette_ram #(
    .COLOUR_WIDTH (COLOUR_WIDTH)
  ) u_palette (
    .clk       (clk),
    .wr_en     (in_fire && (func == FUNC_LOAD)),
    .wr_addr   (in_palette_index),
    .wr_data   (in_palette_value[COLOUR_WIDTH-1:0]),
    .rd_en     (in_fire && (func == FUNC_DATA)),
    .rd_addr   (in_data_byte[NIBBLE_W-1:0]),
    .rd_data_r (rd_data)
  );

  // Run steps and the flush push wait until the output register can take a pixel.
  assign out_free = !out_valid_r || out_ready;

  nrpd_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (in_fire),
    .func     (func),
    .run_len  (in_data_byte[2*NIBBLE_W-1:NIBBLE_W]),
    .cfg      (cfg_r),
    .out_free (out_free),
    .idle     (seq_idle),
    .push     (push)
  );

  // Output register: holds each pixel until its downstream transfer; the sequencer still sees out_ready directly.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (push.vld) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push.vld) begin
      out_pixel_r      <= rd_data;
      out_column_end_r <= push.col_end;
      out_last_r       <= push.last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_pixel      = PIXEL_W'(out_pixel_r);
  assign out_column_end = out_column_end_r;
  assign out_last       = out_last_r;

  // A data byte keeps the block busy after its acceptance, as the run follows the read.
  a_data_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_func == FUNC_DATA)) |=> !in_ready)
    else $error("input accepted during palette read");

  // Never overwrite a pixel that is still waiting for its transfer.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    push.vld |-> (!out_valid_r || out_ready))
    else $error("output register overwritten");

  // Start sequence: multiply then add, then back to idle.
  a_start_len: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_func == FUNC_START)) |-> ##3 in_ready)
    else $error("start item did not complete in three cycles");

  // The sequencer returns to idle once the flagged last pixel is pushed.
  a_last_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (push.vld && push.last) |=> in_ready)
    else $error("sequencer not idle after last pixel");

endmodule
